// ===== rtl/sait_pkg.sv =====
package sait_pkg;

    localparam int NUM_BUCKETS      = 256;
    localparam int SLOTS_PER_BUCKET = 4;
    localparam int BUCKET_BITS      = $clog2(NUM_BUCKETS);
    localparam int SLOT_BITS        = $clog2(SLOTS_PER_BUCKET);
    localparam int USED_BITS        = $clog2(SLOTS_PER_BUCKET + 1);
    localparam int FIFO_DEPTH       = 2;

    localparam logic [63:0] MIX_K1 = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] MIX_K2 = 64'hFF51AFD7ED558CCD;
    localparam int MIX_SHIFT = 33;

    localparam logic [2:0] ST_INACTIVE = 3'd0;
    localparam logic [2:0] ST_NOOP     = 3'd1;
    localparam logic [2:0] ST_OVERFLOW = 3'd2;
    localparam logic [2:0] ST_INSERTED = 3'd3;
    localparam logic [2:0] ST_UPDATED  = 3'd4;
    localparam logic [2:0] ST_REMOVED  = 3'd5;
    localparam logic [2:0] ST_FOUND    = 3'd6;
    localparam logic [2:0] ST_NOTFOUND = 3'd7;

    localparam logic OP_LOOKUP  = 1'b0;
    localparam logic OP_PUBLISH = 1'b1;

    typedef struct packed {
        logic        op;
        logic [63:0] device_id;
        logic [63:0] inode_number;
        logic [31:0] ref_count;
        logic [31:0] access_mask;
        logic [31:0] sharing_mask;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  bucket_index;
        logic [1:0]  slot_index;
        logic [31:0] stored_refs;
        logic [31:0] stored_access;
        logic [31:0] stored_sharing;
        logic [31:0] bucket_seq;
        logic [2:0]  bucket_used;
    } rsp_t;

    // classified work item passed from front to back
    typedef struct packed {
        req_t                   req;
        logic                   active;
        logic [BUCKET_BITS-1:0] bucket;
    } work_t;

    // one slot as stored
    typedef struct packed {
        logic [63:0] dev;
        logic [63:0] ino;
        logic [31:0] refs;
        logic [31:0] acc;
        logic [31:0] shr;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);
    // bucket row: slots plus sequence number and occupancy
    localparam int ROW_W  = SLOTS_PER_BUCKET * SLOT_W + 32 + USED_BITS;

endpackage

// ===== rtl/sait_if.sv =====
interface sait_req_if;
    import sait_pkg::*;
    logic valid;
    logic ready;
    req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sait_rsp_if;
    import sait_pkg::*;
    logic valid;
    logic ready;
    rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sait_cfg_if;
    logic valid;
    logic ready;
    logic data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/sait_ram.sv =====
module sait_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ===== rtl/sait_front.sv =====
module sait_front
    import sait_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  req_t  in_data,
    input  logic  active,
    output logic  wk_valid,
    input  logic  wk_ready,
    output work_t wk_data
);
    // four-stage hash: partial products, sum and xorshift, partial products, sum and xorshift
    logic                   s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    req_t                   s1_req_reg, s2_req_reg, s3_req_reg, s4_req_reg;
    logic                   s1_act_reg, s2_act_reg, s3_act_reg, s4_act_reg;
    logic [63:0]            s1_ll_reg, s3_ll_reg;
    logic [31:0]            s1_x_reg, s3_x_reg;
    logic [63:0]            s2_g_reg;
    logic [BUCKET_BITS-1:0] s4_bucket_reg;
    logic [63:0]            m1_ll, m3_ll, h1, g1, h2, h3;
    logic [31:0]            m1_x, m3_x;
    logic                   adv1, adv2, adv3, adv4;

    assign adv4     = !s4_valid_reg || wk_ready;
    assign adv3     = !s3_valid_reg || adv4;
    assign adv2     = !s2_valid_reg || adv3;
    assign adv1     = !s1_valid_reg || adv2;
    assign in_ready = adv1;

    // 64-bit products mod 2^64 from 32-bit pieces; cross terms only matter in the low 32 bits
    assign m1_ll = 64'(in_data.device_id[31:0]) * 64'(MIX_K1[31:0]);
    assign m1_x  = in_data.device_id[63:32] * MIX_K1[31:0]
                 + in_data.device_id[31:0] * MIX_K1[63:32];
    assign h1    = s1_ll_reg + {s1_x_reg, 32'd0} + s1_req_reg.inode_number;
    assign g1    = h1 ^ (h1 >> MIX_SHIFT);
    assign m3_ll = 64'(s2_g_reg[31:0]) * 64'(MIX_K2[31:0]);
    assign m3_x  = s2_g_reg[63:32] * MIX_K2[31:0] + s2_g_reg[31:0] * MIX_K2[63:32];
    assign h2    = s3_ll_reg + {s3_x_reg, 32'd0};
    assign h3    = h2 ^ (h2 >> MIX_SHIFT);

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1) s1_valid_reg <= in_valid;
            if (adv2) s2_valid_reg <= s1_valid_reg;
            if (adv3) s3_valid_reg <= s2_valid_reg;
            if (adv4) s4_valid_reg <= s3_valid_reg;
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            s1_req_reg <= in_data;
            s1_act_reg <= active;
            s1_ll_reg  <= m1_ll;
            s1_x_reg   <= m1_x;
        end
        if (adv2)
        begin
            s2_req_reg <= s1_req_reg;
            s2_act_reg <= s1_act_reg;
            s2_g_reg   <= g1;
        end
        if (adv3)
        begin
            s3_req_reg <= s2_req_reg;
            s3_act_reg <= s2_act_reg;
            s3_ll_reg  <= m3_ll;
            s3_x_reg   <= m3_x;
        end
        if (adv4)
        begin
            s4_req_reg    <= s3_req_reg;
            s4_act_reg    <= s3_act_reg;
            s4_bucket_reg <= h3[BUCKET_BITS-1:0];
        end
    end

    assign wk_valid       = s4_valid_reg;
    assign wk_data.req    = s4_req_reg;
    assign wk_data.active = s4_act_reg;
    assign wk_data.bucket = s4_bucket_reg;
endmodule

// ===== rtl/sait_fifo.sv =====
module sait_fifo
    import sait_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  wr_valid,
    output logic  wr_ready,
    input  work_t wr_data,
    output logic  rd_valid,
    input  logic  rd_ready,
    output work_t rd_data
);
    localparam int PW = $clog2(FIFO_DEPTH);

    work_t         buf_reg [FIFO_DEPTH];
    logic [PW-1:0] wp_reg, rp_reg;
    logic [PW:0]   cnt_reg;
    logic          wr_fire, rd_fire;

    assign wr_ready = cnt_reg != (PW+1)'(FIFO_DEPTH);
    assign rd_valid = cnt_reg != '0;
    assign rd_data  = buf_reg[rp_reg];
    assign wr_fire  = wr_valid && wr_ready;
    assign rd_fire  = rd_valid && rd_ready;

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_fire) wp_reg <= wp_reg + 1'b1;
            if (rd_fire) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (PW+1)'(wr_fire) - (PW+1)'(rd_fire);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_fire) buf_reg[wp_reg] <= wr_data;
    end
endmodule

// ===== rtl/sait_back.sv =====
module sait_back
    import sait_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  wk_valid,
    output logic  wk_ready,
    input  work_t wk_data,
    output logic  out_valid,
    input  logic  out_ready,
    output rsp_t  out_data
);
    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_READ  = 2'd2;
    localparam logic [1:0] S_EXEC  = 2'd3;

    logic [1:0]             state_reg, state_next;
    logic [BUCKET_BITS-1:0] clr_reg;
    work_t                  cur_reg;
    logic                   ov_reg;
    rsp_t                   rsp_reg, rsp_next;

    logic                   we, re;
    logic [BUCKET_BITS-1:0] waddr;
    logic [ROW_W-1:0]       wdata, rdata;

    sait_ram #(.WIDTH(ROW_W), .DEPTH(NUM_BUCKETS)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (wk_data.bucket),
        .rdata (rdata)
    );

    // unpack row
    slot_t                 sl     [SLOTS_PER_BUCKET];
    slot_t                 nsl    [SLOTS_PER_BUCKET];
    logic [31:0]           seq, nseq;
    logic [USED_BITS-1:0]  used, nused;
    logic [SLOTS_PER_BUCKET-1:0] hitv, empv;
    logic                  hit, emp, do_write;
    logic [SLOT_BITS-1:0]  hidx, eidx, sidx;
    logic [2:0]            st;
    logic                  have_slot;
    slot_t                 wslot;
    logic [ROW_W-1:0]      nrow;

    always_comb
    begin
        for (int i = 0; i < SLOTS_PER_BUCKET; i++)
        begin
            sl[i]   = rdata[i*SLOT_W +: SLOT_W];
            hitv[i] = sl[i].dev == cur_reg.req.device_id
                      && sl[i].ino == cur_reg.req.inode_number;
            empv[i] = sl[i].dev == '0;
        end
        seq  = rdata[SLOTS_PER_BUCKET*SLOT_W +: 32];
        used = rdata[SLOTS_PER_BUCKET*SLOT_W+32 +: USED_BITS];
    end

    // first hit and first empty slot
    always_comb
    begin
        hit  = 1'b0;
        emp  = 1'b0;
        hidx = '0;
        eidx = '0;
        for (int i = SLOTS_PER_BUCKET-1; i >= 0; i--)
        begin
            if (hitv[i])
            begin
                hit  = 1'b1;
                hidx = SLOT_BITS'(i);
            end
            if (empv[i])
            begin
                emp  = 1'b1;
                eidx = SLOT_BITS'(i);
            end
        end
        if (cur_reg.req.device_id == '0)
        begin
            hit = 1'b0;
        end
    end

    // decide the step
    always_comb
    begin
        do_write  = 1'b0;
        have_slot = 1'b0;
        sidx      = hit ? hidx : eidx;
        nseq      = seq;
        nused     = used;
        wslot     = cur_reg.req.ref_count == '0 ? slot_t'('0)
                  : {cur_reg.req.device_id, cur_reg.req.inode_number,
                     cur_reg.req.ref_count, cur_reg.req.access_mask,
                     cur_reg.req.sharing_mask};
        if (cur_reg.req.op == OP_LOOKUP)
        begin
            st        = hit ? ST_FOUND : ST_NOTFOUND;
            have_slot = hit;
        end
        else if (cur_reg.req.device_id == '0 || (!hit && cur_reg.req.ref_count == '0))
        begin
            st = ST_NOOP;
        end
        else if (!hit && !emp)
        begin
            st = ST_OVERFLOW;
        end
        else
        begin
            do_write  = 1'b1;
            have_slot = 1'b1;
            nseq      = seq + 32'd2;
            if (cur_reg.req.ref_count == '0)
            begin
                st = ST_REMOVED;
                if (used != '0) nused = used - 1'b1;
            end
            else if (!hit)
            begin
                st    = ST_INSERTED;
                nused = used + 1'b1;
            end
            else
            begin
                st = ST_UPDATED;
            end
        end
        for (int i = 0; i < SLOTS_PER_BUCKET; i++)
        begin
            nsl[i] = (do_write && sidx == SLOT_BITS'(i)) ? wslot : sl[i];
            nrow[i*SLOT_W +: SLOT_W] = nsl[i];
        end
        nrow[SLOTS_PER_BUCKET*SLOT_W +: 32] = nseq;
        nrow[SLOTS_PER_BUCKET*SLOT_W+32 +: USED_BITS] = nused;
    end

    // result beat
    always_comb
    begin
        rsp_next              = '0;
        rsp_next.bucket_index = 8'(cur_reg.bucket);
        if (cur_reg.active)
        begin
            rsp_next.status      = st;
            rsp_next.bucket_seq  = nseq;
            rsp_next.bucket_used = 3'(nused);
            if (have_slot)
            begin
                rsp_next.slot_index     = 2'(sidx);
                rsp_next.stored_refs    = nsl[sidx].refs;
                rsp_next.stored_access  = nsl[sidx].acc;
                rsp_next.stored_sharing = nsl[sidx].shr;
            end
        end
    end

    // a new beat may enter while the held result leaves in the same cycle
    assign wk_ready  = state_reg == S_IDLE && (!ov_reg || out_ready);
    assign re        = wk_valid && wk_ready;
    assign we        = state_reg == S_CLEAR || (state_reg == S_READ && do_write && cur_reg.active);
    assign waddr     = state_reg == S_CLEAR ? clr_reg : cur_reg.bucket;
    assign wdata     = state_reg == S_CLEAR ? '0 : nrow;
    assign out_valid = ov_reg;
    assign out_data  = rsp_reg;

    // sequencer: clear sweep, then read then modify-write per beat
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: if (clr_reg == BUCKET_BITS'(NUM_BUCKETS-1)) state_next = S_IDLE;
            S_IDLE:  if (re) state_next = S_READ;
            S_READ:  state_next = S_IDLE;
            S_EXEC:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR) clr_reg <= clr_reg + 1'b1;
            if (state_reg == S_READ) ov_reg <= 1'b1;
            else if (out_ready) ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re) cur_reg <= wk_data;
        if (state_reg == S_READ) rsp_reg <= rsp_next;
    end
endmodule

// ===== rtl/set_assoc_inode_hash_table_top.sv =====
// Set-associative inode table: 256 buckets of 4 slots keyed by (device, inode).
// A request passes a 4-stage hash pipeline built from 32-bit partial products, waits
// in a 2-deep queue, then the back end reads the bucket row and writes it back in the
// cycle after; the back end takes a new item only once the previous row is written back.
// A result not taken holds off the next bucket read.
// After reset a clearing pass zeroes all 256 buckets before the back end takes items.
module set_assoc_inode_hash_table_top
    import sait_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    sait_req_if.sink  in_ch,
    sait_rsp_if.source out_ch,
    sait_cfg_if.sink  cfg
);
    logic  active_reg;
    logic  wk_valid, wk_ready, q_valid, q_ready;
    work_t wk_data, q_data;

    assign cfg.ready = 1'b1;

    // activation register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) active_reg <= 1'b0;
        else if (cfg.valid) active_reg <= cfg.data;
    end

    sait_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
        .active(active_reg),
        .wk_valid(wk_valid), .wk_ready(wk_ready), .wk_data(wk_data)
    );

    sait_fifo u_fifo (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(wk_valid), .wr_ready(wk_ready), .wr_data(wk_data),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
    );

    sait_back u_back (
        .clk(clk), .rst_n(rst_n),
        .wk_valid(q_valid), .wk_ready(q_ready), .wk_data(q_data),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
    );
endmodule

// ===== bench/tb_set_assoc_inode_hash_table_top.sv =====
module tb_set_assoc_inode_hash_table_top;
    import sait_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOT_BUCKETS  = 4;
    localparam int KEYS_PER_HOT = 6;
    localparam int COLD_KEYS    = 40;
    localparam int POOL_SIZE    = HOT_BUCKETS * KEYS_PER_HOT + COLD_KEYS;
    localparam int PHASE_ITEMS  = 475;
    localparam int SETTLE       = 20;
    localparam int STALL_LIMIT  = 20000;

    // Tracks the table contents and holds the responses still owed by the block
    class table_scoreboard;
        rsp_t        owed[$];
        int          errors;
        bit          active;
        logic [63:0] dev_q [NUM_BUCKETS*SLOTS_PER_BUCKET];
        logic [63:0] ino_q [NUM_BUCKETS*SLOTS_PER_BUCKET];
        logic [31:0] refs_q[NUM_BUCKETS*SLOTS_PER_BUCKET];
        logic [31:0] acc_q [NUM_BUCKETS*SLOTS_PER_BUCKET];
        logic [31:0] shr_q [NUM_BUCKETS*SLOTS_PER_BUCKET];
        logic [31:0] seq_q [NUM_BUCKETS];
        logic [2:0]  used_q[NUM_BUCKETS];

        function new();
            errors = 0;
            active = 0;
            foreach (dev_q[i])
            begin
                dev_q[i] = '0; ino_q[i] = '0; refs_q[i] = '0; acc_q[i] = '0; shr_q[i] = '0;
            end
            foreach (seq_q[i])
            begin
                seq_q[i] = '0; used_q[i] = '0;
            end
        endfunction

        // multiply-xorshift mix, low bits pick the bucket
        static function int bucket_of(logic [63:0] dev, logic [63:0] ino);
            logic [63:0] h;
            h = dev * MIX_K1 + ino;
            h = h ^ (h >> MIX_SHIFT);
            h = h * MIX_K2;
            h = h ^ (h >> MIX_SHIFT);
            return int'(h % NUM_BUCKETS);
        endfunction

        function void note_request(req_t r);
            rsp_t e;
            int   b, base, hit, empty, slot, s;
            e = '0;
            b = bucket_of(r.device_id, r.inode_number);
            base = b * SLOTS_PER_BUCKET;
            hit = -1; empty = -1; slot = -1;
            e.bucket_index = b[7:0];
            if (!active)
            begin
                e.status = ST_INACTIVE;
                owed.push_back(e);
                return;
            end
            if (r.device_id != 0)
            begin
                for (int i = 0; i < SLOTS_PER_BUCKET; i++)
                begin
                    if (hit < 0 && dev_q[base+i] == r.device_id
                        && ino_q[base+i] == r.inode_number)
                        hit = i;
                    if (hit < 0 && dev_q[base+i] == 0 && empty < 0)
                        empty = i;
                end
            end
            if (r.op == OP_LOOKUP)
            begin
                e.status = (hit >= 0) ? ST_FOUND : ST_NOTFOUND;
                slot = hit;
            end
            else if (r.device_id == 0 || (hit < 0 && r.ref_count == 0))
                e.status = ST_NOOP;
            else if (hit < 0 && empty < 0)
                e.status = ST_OVERFLOW;
            else
            begin
                slot = (hit >= 0) ? hit : empty;
                s = base + slot;
                if (r.ref_count == 0)
                begin
                    dev_q[s] = '0; ino_q[s] = '0; refs_q[s] = '0; acc_q[s] = '0; shr_q[s] = '0;
                    if (used_q[b] > 0)
                        used_q[b]--;
                    e.status = ST_REMOVED;
                end
                else
                begin
                    if (dev_q[s] == 0)
                    begin
                        used_q[b]++;
                        e.status = ST_INSERTED;
                    end
                    else
                        e.status = ST_UPDATED;
                    dev_q[s]  = r.device_id;
                    ino_q[s]  = r.inode_number;
                    refs_q[s] = r.ref_count;
                    acc_q[s]  = r.access_mask;
                    shr_q[s]  = r.sharing_mask;
                end
                seq_q[b] += 32'd2;
            end
            if (slot >= 0)
            begin
                s = base + slot;
                e.slot_index     = slot[1:0];
                e.stored_refs    = refs_q[s];
                e.stored_access  = acc_q[s];
                e.stored_sharing = shr_q[s];
            end
            e.bucket_seq  = seq_q[b];
            e.bucket_used = used_q[b];
            owed.push_back(e);
        endfunction

        function void check_response(rsp_t got);
            rsp_t e;
            if (owed.size() == 0)
            begin
                $error("unexpected response beat: %p", got);
                errors++;
                return;
            end
            e = owed.pop_front();
            if (got.status !== e.status)
            begin
                $error("status exp %0d got %0d", e.status, got.status); errors++;
            end
            if (got.bucket_index !== e.bucket_index)
            begin
                $error("bucket_index exp %0d got %0d", e.bucket_index, got.bucket_index);
                errors++;
            end
            if (got.slot_index !== e.slot_index)
            begin
                $error("slot_index exp %0d got %0d", e.slot_index, got.slot_index); errors++;
            end
            if (got.stored_refs !== e.stored_refs)
            begin
                $error("stored_refs exp %h got %h", e.stored_refs, got.stored_refs); errors++;
            end
            if (got.stored_access !== e.stored_access)
            begin
                $error("stored_access exp %h got %h", e.stored_access, got.stored_access);
                errors++;
            end
            if (got.stored_sharing !== e.stored_sharing)
            begin
                $error("stored_sharing exp %h got %h", e.stored_sharing, got.stored_sharing);
                errors++;
            end
            if (got.bucket_seq !== e.bucket_seq)
            begin
                $error("bucket_seq exp %h got %h", e.bucket_seq, got.bucket_seq); errors++;
            end
            if (got.bucket_used !== e.bucket_used)
            begin
                $error("bucket_used exp %0d got %0d", e.bucket_used, got.bucket_used); errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    sait_req_if in_ch();
    sait_rsp_if out_ch();
    sait_cfg_if cfg();

    set_assoc_inode_hash_table_top u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg)
    );

    table_scoreboard sb;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          quiet_cycles;
    logic [63:0] pool_dev[POOL_SIZE];
    logic [63:0] pool_ino[POOL_SIZE];

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // response side: random backpressure, check every beat
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_response(out_ch.data);
    end

    // watchdog on cycles with no beat on any channel
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (cfg.valid && cfg.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic send_item(req_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= r;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sb.note_request(r);
    endtask

    task automatic send_fields(logic op, logic [63:0] dev, logic [63:0] ino,
                               logic [31:0] refs, logic [31:0] acc, logic [31:0] shr);
        req_t r;
        r.op = op; r.device_id = dev; r.inode_number = ino;
        r.ref_count = refs; r.access_mask = acc; r.sharing_mask = shr;
        send_item(r);
    endtask

    // drop valid and wait until the block has drained
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.owed.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_active(logic v);
        cfg.valid <= 1'b1;
        cfg.data  <= v;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
        sb.active = v;
        @(posedge clk);
    endtask

    task automatic random_items(int n);
        int          k;
        logic [63:0] dev, ino;
        logic [31:0] refs;
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(99);
            if (k < 80)
            begin
                k = $urandom_range(POOL_SIZE-1);
                dev = pool_dev[k];
                ino = pool_ino[k];
            end
            else if (k < 85)
            begin
                dev = '0;
                ino = rand64();
            end
            else
            begin
                dev = rand64();
                ino = rand64();
            end
            refs = ($urandom_range(3) == 0) ? 32'd0 : $urandom;
            send_fields(($urandom_range(99) < 60) ? OP_PUBLISH : OP_LOOKUP,
                        dev, ino, refs, $urandom, $urandom);
        end
    endtask

    initial
    begin
        int          b, n;
        logic [63:0] d, x;
        sb = new();
        rst_n = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        quiet_cycles = 0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        cfg.valid = 1'b0;
        cfg.data = 1'b0;

        // key pool: a few crowded buckets plus scattered keys
        n = 0;
        for (int h = 0; h < HOT_BUCKETS; h++)
        begin
            b = $urandom_range(NUM_BUCKETS-1);
            for (int j = 0; j < KEYS_PER_HOT; j++)
            begin
                do
                begin
                    d = rand64();
                    x = rand64();
                end
                while (d == 0 || table_scoreboard::bucket_of(d, x) != b);
                pool_dev[n] = d; pool_ino[n] = x; n++;
            end
        end
        for (int j = 0; j < COLD_KEYS; j++)
        begin
            pool_dev[n] = rand64() | 64'd1; pool_ino[n] = rand64(); n++;
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // inactive table: everything reports inactive
        send_fields(OP_PUBLISH, pool_dev[0], pool_ino[0], 32'd5, 32'd1, 32'd2);
        send_fields(OP_LOOKUP, '1, '1, '0, '0, '0);
        drain();
        write_active(1'b1);

        // directed: device zero, extremes, insert/update/remove, overflow
        send_fields(OP_LOOKUP, '0, '1, '1, '1, '1);
        send_fields(OP_PUBLISH, '0, '0, '1, '1, '1);
        send_fields(OP_PUBLISH, '1, '1, '1, '1, '1);
        send_fields(OP_LOOKUP, '1, '1, '0, '0, '0);
        send_fields(OP_PUBLISH, '1, '1, 32'd1, '0, '0);
        send_fields(OP_PUBLISH, '1, '1, 32'd0, '1, '1);
        send_fields(OP_LOOKUP, '1, '1, '0, '0, '0);
        send_fields(OP_PUBLISH, '1, '1, 32'd0, '0, '0);
        send_fields(OP_PUBLISH, 64'd1, '0, 32'd7, 32'hAAAA5555, 32'h5555AAAA);
        for (int j = 0; j < KEYS_PER_HOT; j++)
            send_fields(OP_PUBLISH, pool_dev[j], pool_ino[j], 32'(j + 1), $urandom, $urandom);
        send_fields(OP_LOOKUP, pool_dev[KEYS_PER_HOT-1], pool_ino[KEYS_PER_HOT-1],
                    '0, '0, '0);
        send_fields(OP_PUBLISH, pool_dev[1], pool_ino[1], 32'd0, '0, '0);
        send_fields(OP_PUBLISH, pool_dev[1], pool_ino[1], 32'd0, '0, '0);
        send_fields(OP_PUBLISH, pool_dev[KEYS_PER_HOT-1], pool_ino[KEYS_PER_HOT-1],
                    32'd9, '1, '0);
        drain();

        // store survives a toggle of the enable
        write_active(1'b0);
        send_fields(OP_LOOKUP, pool_dev[0], pool_ino[0], '0, '0, '0);
        drain();
        write_active(1'b1);

        // random traffic across the idle/stall phases
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            random_items(PHASE_ITEMS);
            drain();
            if (p == 1)
            begin
                write_active(1'b0);
                random_items(20);
                drain();
                write_active(1'b1);
            end
        end

        if (sb.errors == 0 && sb.owed.size() == 0)
            $display("No mismatches found");
        else
        begin
            if (sb.owed.size() != 0)
                $error("%0d responses never arrived", sb.owed.size());
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
